@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Each macro takes a label, a clock, a disable condition and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, clk, dis, expr, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bmpdec_pkg.sv @@
// ----------------------------------------------------------------------------
// BMP decoder package
// Beat types, status codes and sizing constants shared by the decoder and its
// checker.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

   // Default number of bits for a pixel coordinate counter.
   localparam int COORD_BITS_DEF = 16;

   // Result status codes.
   localparam logic [2:0] STAT_PIXEL       = 3'd0;
   localparam logic [2:0] STAT_BAD_SIG     = 3'd1;
   localparam logic [2:0] STAT_BAD_HDR_SZ  = 3'd2;
   localparam logic [2:0] STAT_BAD_PLANES  = 3'd3;
   localparam logic [2:0] STAT_BAD_COMPR   = 3'd4;
   localparam logic [2:0] STAT_BAD_WIDTH   = 3'd5;
   localparam logic [2:0] STAT_BAD_BPP     = 3'd6;
   localparam logic [2:0] STAT_TOO_LARGE   = 3'd7;

   // Header constants.
   localparam logic [15:0] BMP_SIGNATURE   = 16'h4D42;
   localparam logic [31:0] INFO_HDR_SIZE   = 32'd40;
   localparam logic [15:0] BPP_RGB         = 16'd24;
   localparam logic [15:0] BPP_RGBA        = 16'd32;
   localparam logic [5:0]  SIG_LAST_BYTE   = 6'd13;
   localparam logic [5:0]  HDR_LAST_BYTE   = 6'd53;
   localparam logic [7:0]  ALPHA_OPAQUE    = 8'd255;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [2:0]  status;
      logic        last_pixel;
   } rsp_payload_type;

endpackage

@@ hdl/bmp_stream_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// BMP stream pixel decoder
// Parses a BMP file arriving one byte per beat and emits one beat per decoded
// pixel, or one status beat when the header is rejected.
// ----------------------------------------------------------------------------
// The decoder takes one file byte on every cycle in which req_valid is high
// and req_stall is low, sustaining one byte per clock for as long as the
// result side keeps up. Each byte is handled in a single registered step: the
// header field registers, pixel counters and the result register (or, while it
// is held, the skid register) are all updated at the clock edge that accepts
// the byte; a beat is registered from the byte that completes it. A two-entry
// output buffer (result register plus skid register) sits in front of the
// result port; req_stall rises only when both entries hold beats, so a stall
// on the result side reaches the input side via the skid entry, and no beat is
// lost. A byte with frame_start set always restarts parsing with that byte as
// the first header byte. The 54-byte header is checked for signature, header
// size, plane count, compression, width, image size and bit count, in that
// order; the first failure produces one status beat with all other fields
// zero, and further bytes are ignored until the next frame start. Pixel data
// is taken to begin directly after the header. Coordinates are counted with
// COORD_BITS bits, and an image whose width or height magnitude exceeds
// 2**COORD_BITS - 1 is rejected as too large.
module bmp_stream_pixel_decoder #(
   parameter int COORD_BITS = bmpdec_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bmpdec_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bmpdec_pkg::rsp_payload_type rsp_payload
);

   // Parser phases.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_PIXELS = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // Largest width or height magnitude that the coordinate counters can hold.
   localparam logic [31:0] SIZE_LIMIT = 32'((33'd1 << COORD_BITS) - 33'd1);

   // Control state.
   logic [2:0] phase_ff, phase_in;
   logic [5:0] hdr_cnt_ff, hdr_cnt_in;

   // Raw header fields, assembled little-endian by shifting bytes in from the top.
   logic [15:0] sig_ff, sig_in;
   logic [31:0] info_size_ff, info_size_in;
   logic [31:0] width_word_ff, width_word_in;
   logic [31:0] height_word_ff, height_word_in;
   logic [15:0] planes_ff, planes_in;
   logic [15:0] bpp_ff, bpp_in;
   logic [31:0] compr_ff, compr_in;

   // Image geometry captured when the header passes its checks.
   logic [COORD_BITS-1:0] width_ff, width_in;
   logic [COORD_BITS-1:0] hmag_ff, hmag_in;
   logic                  top_down_ff, top_down_in;
   logic                  wide_ff, wide_in;

   // Pixel unpacking state.
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] line_ff, line_in;
   logic [1:0]            bip_ff, bip_in;
   logic [1:0]            pad_ff, pad_in;
   logic [23:0]           color_ff, color_in;

   // Output buffer.
   bmpdec_pkg::rsp_payload_type rsp_ff, rsp_in, skid_ff, skid_in, res_new;
   logic rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic produce;

   // Per-byte working values.
   logic                  accept;
   logic                  pop;
   logic [7:0]            din;
   logic [2:0]            ph;
   logic [5:0]            k;
   logic [31:0]           hmag32;
   logic [1:0]            last_idx;
   logic [COORD_BITS-1:0] row;
   logic                  row_end;
   logic                  last;
   logic [31:0]           x32;
   logic [31:0]           row32;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign din       = req_payload.data_byte;
   assign req_stall = skid_valid_ff;

   // Height magnitude for bottom-up (positive) and top-down (negative) images.
   assign hmag32 = height_word_ff[31] ? (32'd0 - height_word_ff) : height_word_ff;

   // Pixel position of the byte that completes a pixel.
   assign row     = top_down_ff ? line_ff : (hmag_ff - COORD_BITS'(1) - line_ff);
   assign row_end = (col_ff == width_ff - COORD_BITS'(1));
   assign last    = row_end && (line_ff == hmag_ff - COORD_BITS'(1));
   assign x32     = 32'(col_ff);
   assign row32   = 32'(row);
   assign last_idx = wide_ff ? 2'd3 : 2'd2;

   always_comb begin
      phase_in       = phase_ff;
      hdr_cnt_in     = hdr_cnt_ff;
      sig_in         = sig_ff;
      info_size_in   = info_size_ff;
      width_word_in  = width_word_ff;
      height_word_in = height_word_ff;
      planes_in      = planes_ff;
      bpp_in         = bpp_ff;
      compr_in       = compr_ff;
      width_in       = width_ff;
      hmag_in        = hmag_ff;
      top_down_in    = top_down_ff;
      wide_in        = wide_ff;
      col_in         = col_ff;
      line_in        = line_ff;
      bip_in         = bip_ff;
      pad_in         = pad_ff;
      color_in       = color_ff;
      res_new        = '0;
      produce        = 1'b0;

      // A frame start restarts the header with this byte as byte zero.
      ph = req_payload.frame_start ? PH_HEADER : phase_ff;
      k  = req_payload.frame_start ? 6'd0 : hdr_cnt_ff;

      if (accept) begin
         phase_in = ph;
         case (ph)
            PH_HEADER: begin
               hdr_cnt_in = k + 6'd1;
               if (k inside {[6'd0:6'd1]}) begin
                  sig_in = {din, sig_ff[15:8]};
               end else if (k inside {[6'd14:6'd17]}) begin
                  info_size_in = {din, info_size_ff[31:8]};
               end else if (k inside {[6'd18:6'd21]}) begin
                  width_word_in = {din, width_word_ff[31:8]};
               end else if (k inside {[6'd22:6'd25]}) begin
                  height_word_in = {din, height_word_ff[31:8]};
               end else if (k inside {[6'd26:6'd27]}) begin
                  planes_in = {din, planes_ff[15:8]};
               end else if (k inside {[6'd28:6'd29]}) begin
                  bpp_in = {din, bpp_ff[15:8]};
               end else if (k inside {[6'd30:6'd33]}) begin
                  compr_in = {din, compr_ff[31:8]};
               end

               if (k == bmpdec_pkg::SIG_LAST_BYTE && sig_ff != bmpdec_pkg::BMP_SIGNATURE) begin
                  produce        = 1'b1;
                  res_new.status = bmpdec_pkg::STAT_BAD_SIG;
                  phase_in       = PH_DONE;
               end else if (k == bmpdec_pkg::HDR_LAST_BYTE) begin
                  // All fields end by byte 33, so the registered values are complete.
                  if (info_size_ff != bmpdec_pkg::INFO_HDR_SIZE) begin
                     produce        = 1'b1;
                     res_new.status = bmpdec_pkg::STAT_BAD_HDR_SZ;
                  end else if (planes_ff != 16'd1) begin
                     produce        = 1'b1;
                     res_new.status = bmpdec_pkg::STAT_BAD_PLANES;
                  end else if (compr_ff != 32'd0) begin
                     produce        = 1'b1;
                     res_new.status = bmpdec_pkg::STAT_BAD_COMPR;
                  end else if (width_word_ff == 32'd0 || width_word_ff[31]) begin
                     produce        = 1'b1;
                     res_new.status = bmpdec_pkg::STAT_BAD_WIDTH;
                  end else if (width_word_ff > SIZE_LIMIT || hmag32 > SIZE_LIMIT) begin
                     produce        = 1'b1;
                     res_new.status = bmpdec_pkg::STAT_TOO_LARGE;
                  end else if (bpp_ff != bmpdec_pkg::BPP_RGB && bpp_ff != bmpdec_pkg::BPP_RGBA) begin
                     produce        = 1'b1;
                     res_new.status = bmpdec_pkg::STAT_BAD_BPP;
                  end

                  if (produce) begin
                     phase_in = PH_DONE;
                  end else begin
                     width_in    = width_word_ff[COORD_BITS-1:0];
                     hmag_in     = hmag32[COORD_BITS-1:0];
                     top_down_in = height_word_ff[31];
                     wide_in     = (bpp_ff == bmpdec_pkg::BPP_RGBA);
                     col_in      = '0;
                     line_in     = '0;
                     bip_in      = 2'd0;
                     pad_in      = 2'd0;
                     color_in    = '0;
                     // A zero-height image has nothing to decode.
                     phase_in    = (hmag32 == 32'd0) ? PH_DONE : PH_PIXELS;
                  end
               end
            end

            PH_PIXELS: begin
               if (bip_ff < last_idx) begin
                  case (bip_ff)
                     2'd0:    color_in[7:0]   = din;
                     2'd1:    color_in[15:8]  = din;
                     default: color_in[23:16] = din;
                  endcase
                  bip_in = bip_ff + 2'd1;
               end else begin
                  produce           = 1'b1;
                  res_new.pixel_x   = x32[15:0];
                  res_new.pixel_row = row32[15:0];
                  res_new.red       = wide_ff ? color_ff[23:16] : din;
                  res_new.green     = color_ff[15:8];
                  res_new.blue      = color_ff[7:0];
                  res_new.alpha     = wide_ff ? din : bmpdec_pkg::ALPHA_OPAQUE;
                  res_new.status    = bmpdec_pkg::STAT_PIXEL;
                  res_new.last_pixel = last;
                  bip_in   = 2'd0;
                  color_in = '0;
                  col_in   = col_ff + COORD_BITS'(1);
                  if (last) begin
                     phase_in = PH_DONE;
                  end else if (row_end) begin
                     col_in  = '0;
                     line_in = line_ff + COORD_BITS'(1);
                     // 24-bit rows are padded to a multiple of four bytes.
                     if (!wide_ff && width_ff[1:0] != 2'd0) begin
                        pad_in   = width_ff[1:0];
                        phase_in = PH_PAD;
                     end
                  end
               end
            end

            PH_PAD: begin
               pad_in = pad_ff - 2'd1;
               if (pad_in == 2'd0) begin
                  phase_in = PH_PIXELS;
               end
            end

            default: begin
               // Idle and done ignore bytes until the next frame start.
            end
         endcase
      end
   end

   // Two-entry output buffer. The skid entry fills only when the result
   // register is held; while it is full no byte is accepted.
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = res_new;
            rsp_valid_in = produce;
         end
      end else if (produce) begin
         skid_in       = res_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_cnt_ff    <= 6'd0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff         <= sig_in;
      info_size_ff   <= info_size_in;
      width_word_ff  <= width_word_in;
      height_word_ff <= height_word_in;
      planes_ff      <= planes_in;
      bpp_ff         <= bpp_in;
      compr_ff       <= compr_in;
      width_ff       <= width_in;
      hmag_ff        <= hmag_in;
      top_down_ff    <= top_down_in;
      wide_ff        <= wide_in;
      col_ff         <= col_in;
      line_ff        <= line_in;
      bip_ff         <= bip_in;
      pad_ff         <= pad_in;
      color_ff       <= color_in;
      rsp_ff         <= rsp_in;
      skid_ff        <= skid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/bmpdec_checker.sv @@
// ----------------------------------------------------------------------------
// BMP decoder port checker
// Watches the decoder's ports and flags result beats or flow control that
// the decoder can never legally show.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpdec_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input bmpdec_pkg::rsp_payload_type rsp_payload
);

   logic err_beat;
   logic err_clean;

   assign err_beat  = rsp_valid && (rsp_payload.status != bmpdec_pkg::STAT_PIXEL);
   assign err_clean = (rsp_payload.pixel_x == 16'd0) && (rsp_payload.pixel_row == 16'd0) &&
                      (rsp_payload.red == 8'd0) && (rsp_payload.green == 8'd0) &&
                      (rsp_payload.blue == 8'd0) && (rsp_payload.alpha == 8'd0) &&
                      !rsp_payload.last_pixel;

   // A held result beat stays valid and unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result beat changed while stalled")

   // The input side is only throttled while a result beat is waiting.
   `ASSERT_IMPLY(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid, "input stalled with no result pending")

   // A status beat carries nothing but its status code.
   `ASSERT_IMPLY(a_err_clean, clock, reset, err_beat, err_clean, "status beat carries pixel data")

   // Reset empties the output buffer.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall, "output buffer not empty after reset")

endmodule

bind bmp_stream_pixel_decoder bmpdec_checker u_bmpdec_checker (.*);

@@ tb/bmp_stream_pixel_decoder_test.sv @@
// ----------------------------------------------------------------------------
// BMP stream pixel decoder testbench
// Feeds whole, damaged and cut-short BMP files into the decoder one byte per
// beat, predicts every pixel and status beat with a cycle-free model of the
// parser, and checks the result stream field by field under random idling on
// both channels.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_decoder_test;

   // Largest coordinate the decoder accepts with its default counter width.
   localparam logic [31:0] COORD_LIMIT = (32'd1 << bmpdec_pkg::COORD_BITS_DEF) - 32'd1;
   localparam logic [15:0] ONE_PLANE = 16'd1;
   localparam int HEADER_BYTES = 54;
   // Cycles without any beat on either channel before the run is abandoned.
   // It lies far beyond the longest idle stretch that pick_idle_cycles gives
   // either side, so a working decoder never comes near it.
   localparam int WATCHDOG_LIMIT = 5000;
   // Quiet period at the end; longer than the longest result-side stall.
   localparam int DRAIN_CYCLES = 60;

   typedef enum logic [2:0] {
      PHASE_IDLE,
      PHASE_HEADER,
      PHASE_PIXELS,
      PHASE_PAD,
      PHASE_DONE
   } parse_phase_type;

   // Header fields that a file can be built with a damaged copy of.
   typedef enum int {
      FAULT_NONE,
      FAULT_SIGNATURE,
      FAULT_INFO_SIZE,
      FAULT_PLANES,
      FAULT_COMPRESSION
   } header_fault_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   bmpdec_pkg::req_payload_type req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   bmpdec_pkg::rsp_payload_type rsp_payload;

   bmp_stream_pixel_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // File bytes waiting to be driven, and decoded beats waiting to be seen.
   bmpdec_pkg::req_payload_type file_bytes[$];
   bmpdec_pkg::rsp_payload_type expected_pixels[$];
   int                          mismatch_count = 0;

   // ------------------------------------------------------------------------
   // Parser state of the prediction. It mirrors what the decoder must hold:
   // the raw little-endian header fields, the pixel position and the bytes
   // of the pixel being assembled.
   // ------------------------------------------------------------------------
   parse_phase_type parse_phase = PHASE_IDLE;
   logic [5:0]      hdr_count = '0;
   logic [15:0]     signature = '0;
   logic [31:0]     info_size = '0;
   logic [15:0]     planes = '0;
   logic [15:0]     bit_count = '0;
   logic [31:0]     compression = '0;
   logic [31:0]     img_width = '0;
   logic [31:0]     img_height = '0;
   logic [15:0]     column = '0;
   logic [15:0]     line = '0;
   logic [1:0]      byte_in_pixel = '0;
   logic [1:0]      pad_left = '0;
   logic [23:0]     color_bytes = '0;

   // A rejected header yields one beat carrying only the status code, and
   // the rest of the file is ignored.
   task automatic reject_file(input logic [2:0] code);
      bmpdec_pkg::rsp_payload_type beat;
      beat = '0;
      beat.status = code;
      expected_pixels.push_back(beat);
      parse_phase = PHASE_DONE;
   endtask

   // Advances the parser by one accepted byte and queues the beat, if any,
   // that this byte completes.
   task automatic decode_file_byte(input bmpdec_pkg::req_payload_type in_beat);
      bmpdec_pkg::rsp_payload_type pix;
      logic [7:0]                  b;
      logic [31:0]                 hmag;
      logic [31:0]                 row_full;
      logic [1:0]                  last_byte;
      logic                        wide;
      logic                        at_end;
      int                          idx;

      b = in_beat.data_byte;
      // A frame start always throws away the current parse, whatever the
      // parser was doing, and this byte becomes byte zero of a new header.
      if (in_beat.frame_start) begin
         hdr_count = '0;
         signature = '0;
         info_size = '0;
         planes = '0;
         bit_count = '0;
         compression = '0;
         img_width = '0;
         img_height = '0;
         column = '0;
         line = '0;
         byte_in_pixel = '0;
         pad_left = '0;
         color_bytes = '0;
         parse_phase = PHASE_HEADER;
      end
      hmag = img_height[31] ? -img_height : img_height;
      wide = (bit_count == bmpdec_pkg::BPP_RGBA);

      case (parse_phase)
         PHASE_HEADER: begin
            idx = int'(hdr_count);
            if (idx < 2) signature[8*idx +: 8] = b;
            else if (idx >= 14 && idx < 18) info_size[8*(idx-14) +: 8] = b;
            else if (idx >= 18 && idx < 22) img_width[8*(idx-18) +: 8] = b;
            else if (idx >= 22 && idx < 26) img_height[8*(idx-22) +: 8] = b;
            else if (idx >= 26 && idx < 28) planes[8*(idx-26) +: 8] = b;
            else if (idx >= 28 && idx < 30) bit_count[8*(idx-28) +: 8] = b;
            else if (idx >= 30 && idx < 34) compression[8*(idx-30) +: 8] = b;
            hdr_count = hdr_count + 6'd1;
            hmag = img_height[31] ? -img_height : img_height;
            if (idx == int'(bmpdec_pkg::SIG_LAST_BYTE) &&
                signature != bmpdec_pkg::BMP_SIGNATURE) begin
               reject_file(bmpdec_pkg::STAT_BAD_SIG);
            end else if (idx == int'(bmpdec_pkg::HDR_LAST_BYTE)) begin
               // The checks run in a fixed order and the first one to fail
               // decides the status code.
               if (info_size != bmpdec_pkg::INFO_HDR_SIZE)
                  reject_file(bmpdec_pkg::STAT_BAD_HDR_SZ);
               else if (planes != ONE_PLANE)
                  reject_file(bmpdec_pkg::STAT_BAD_PLANES);
               else if (compression != '0)
                  reject_file(bmpdec_pkg::STAT_BAD_COMPR);
               else if (img_width == '0 || img_width[31])
                  reject_file(bmpdec_pkg::STAT_BAD_WIDTH);
               else if (img_width > COORD_LIMIT || hmag > COORD_LIMIT)
                  reject_file(bmpdec_pkg::STAT_TOO_LARGE);
               else if (bit_count != bmpdec_pkg::BPP_RGB &&
                        bit_count != bmpdec_pkg::BPP_RGBA)
                  reject_file(bmpdec_pkg::STAT_BAD_BPP);
               else begin
                  column = '0;
                  line = '0;
                  byte_in_pixel = '0;
                  pad_left = '0;
                  color_bytes = '0;
                  // A zero-height image is valid but has nothing to emit.
                  parse_phase = (hmag == '0) ? PHASE_DONE : PHASE_PIXELS;
               end
            end
         end
         PHASE_PIXELS: begin
            last_byte = wide ? 2'd3 : 2'd2;
            if (byte_in_pixel < last_byte) begin
               color_bytes[8*byte_in_pixel +: 8] = b;
               byte_in_pixel = byte_in_pixel + 2'd1;
            end else begin
               // Bytes arrive as B, G, R and, for 32-bit images, A.
               row_full = img_height[31] ? {16'd0, line} : hmag - 32'd1 - {16'd0, line};
               at_end = ({16'd0, column} == img_width - 32'd1) &&
                        ({16'd0, line} == hmag - 32'd1);
               pix.pixel_x = column;
               pix.pixel_row = row_full[15:0];
               pix.red = wide ? color_bytes[23:16] : b;
               pix.green = color_bytes[15:8];
               pix.blue = color_bytes[7:0];
               pix.alpha = wide ? b : bmpdec_pkg::ALPHA_OPAQUE;
               pix.status = bmpdec_pkg::STAT_PIXEL;
               pix.last_pixel = at_end;
               expected_pixels.push_back(pix);
               byte_in_pixel = '0;
               color_bytes = '0;
               column = column + 16'd1;
               if (at_end) begin
                  parse_phase = PHASE_DONE;
               end else if ({16'd0, column} >= img_width) begin
                  column = '0;
                  line = line + 16'd1;
                  // 24-bit rows are padded to a multiple of four bytes.
                  if (!wide && img_width[1:0] != 2'd0) begin
                     pad_left = img_width[1:0];
                     parse_phase = PHASE_PAD;
                  end
               end
            end
         end
         PHASE_PAD: begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 2'd0) parse_phase = PHASE_PIXELS;
         end
         default: begin
            // Idle or finished: bytes without a frame start are dropped.
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building.
   // ------------------------------------------------------------------------

   // Queues one BMP file. The fields that the decoder ignores (file size,
   // offsets, resolution and so on) are filled with random bytes. With a
   // negative cut the whole file goes out, followed by up to four stray bytes;
   // otherwise only the first cut bytes are sent, which leaves the next
   // frame start to land in the middle of this file.
   task automatic queue_bmp_file(input logic [31:0] width, input logic [31:0] height,
                                 input logic [15:0] bpp, input header_fault_type fault,
                                 input int cut);
      logic [7:0]                  hdr [0:HEADER_BYTES-1];
      logic [31:0]                 hmag;
      longint                      row_bytes;
      longint                      total;
      longint                      emit;
      bmpdec_pkg::req_payload_type beat;

      for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
      for (int i = 0; i < 2; i++) begin
         hdr[i] = bmpdec_pkg::BMP_SIGNATURE[8*i +: 8];
         hdr[26+i] = ONE_PLANE[8*i +: 8];
         hdr[28+i] = bpp[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         hdr[14+i] = bmpdec_pkg::INFO_HDR_SIZE[8*i +: 8];
         hdr[18+i] = width[8*i +: 8];
         hdr[22+i] = height[8*i +: 8];
         hdr[30+i] = 8'h00;
      end
      // Flipping one bit is enough to make the field wrong.
      case (fault)
         FAULT_SIGNATURE:   hdr[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
         FAULT_INFO_SIZE:   hdr[14 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
         FAULT_PLANES:      hdr[26 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
         FAULT_COMPRESSION: hdr[30 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
         default: ;
      endcase

      hmag = height[31] ? -height : height;
      row_bytes = longint'(width) * longint'(bpp / 16'd8);
      if (bpp == bmpdec_pkg::BPP_RGB) row_bytes += longint'(width % 4);
      total = HEADER_BYTES + row_bytes * longint'(hmag);
      if (cut < 0) emit = total + $urandom_range(4);
      else emit = cut;

      for (longint n = 0; n < emit; n++) begin
         beat.frame_start = (n == 0);
         beat.data_byte = (n < HEADER_BYTES) ? hdr[n] : 8'($urandom);
         file_bytes.push_back(beat);
      end
   endtask

   // Random bytes; frame starts among them open headers that are mostly
   // rejected on their signature or cut short by the next file.
   task automatic queue_noise(input int count, input bit allow_start);
      bmpdec_pkg::req_payload_type beat;
      for (int n = 0; n < count; n++) begin
         beat.data_byte = 8'($urandom);
         beat.frame_start = allow_start && ($urandom_range(9) == 0);
         file_bytes.push_back(beat);
      end
   endtask

   // Signed small height, zero now and then.
   function automatic logic [31:0] pick_height();
      return 32'($urandom_range(10)) - 32'd5;
   endfunction

   // Idle stretches: most are short, a few are long.
   function automatic int pick_idle_cycles();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      logic [31:0] w;
      logic [31:0] h;
      logic [15:0] bpp;
      int          roll;

      // Directed files. Bytes before any frame start are dropped.
      queue_noise(5, 1'b0);
      // Smallest image in both depths, bottom-up and top-down, with stray
      // bytes after the last pixel.
      queue_bmp_file(32'd1, 32'd1, bmpdec_pkg::BPP_RGB, FAULT_NONE, -1);
      queue_bmp_file(32'd1, -32'd1, bmpdec_pkg::BPP_RGBA, FAULT_NONE, -1);
      // Every row padding length, mixed with both row orders.
      queue_bmp_file(32'd2, 32'd3, bmpdec_pkg::BPP_RGB, FAULT_NONE, -1);
      queue_bmp_file(32'd3, -32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, -1);
      queue_bmp_file(32'd4, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, -1);
      queue_bmp_file(32'd3, 32'd2, bmpdec_pkg::BPP_RGBA, FAULT_NONE, -1);
      // Zero height: accepted header, no beats, trailing bytes ignored.
      queue_bmp_file(32'd5, 32'd0, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES + 6);
      // Each header check on its own.
      queue_bmp_file(32'd2, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_SIGNATURE, HEADER_BYTES + 3);
      queue_bmp_file(32'd2, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_INFO_SIZE, HEADER_BYTES + 3);
      queue_bmp_file(32'd2, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_PLANES, HEADER_BYTES);
      queue_bmp_file(32'd2, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_COMPRESSION, HEADER_BYTES);
      queue_bmp_file(32'd0, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'hFFFF_FFFF, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'h8000_0000, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'h0001_0000, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'd2, 32'h0001_0000, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'd2, 32'hFFFF_0000, bmpdec_pkg::BPP_RGB, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'd2, 32'h8000_0000, bmpdec_pkg::BPP_RGBA, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'd2, 32'd2, 16'd16, FAULT_NONE, HEADER_BYTES);
      queue_bmp_file(32'd2, 32'd2, 16'hFFFF, FAULT_NONE, HEADER_BYTES);
      // Several faults at once: the header size wins over the bit count and
      // the width wins over the size limit.
      queue_bmp_file(32'd2, 32'd2, 16'd8, FAULT_INFO_SIZE, HEADER_BYTES);
      queue_bmp_file(32'h8000_0000, 32'h0002_0000, bmpdec_pkg::BPP_RGB, FAULT_NONE,
                     HEADER_BYTES);
      // Largest legal sizes, cut short after a few pixels: rows near the top of
      // the coordinate range in the bottom-up file and a frame start in mid-pixel.
      queue_bmp_file(COORD_LIMIT, COORD_LIMIT, bmpdec_pkg::BPP_RGB, FAULT_NONE,
                     HEADER_BYTES + 31);
      queue_bmp_file(COORD_LIMIT, -COORD_LIMIT, bmpdec_pkg::BPP_RGBA, FAULT_NONE,
                     HEADER_BYTES + 42);
      // A frame start in the middle of a header.
      queue_bmp_file(32'd2, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, 20);
      queue_bmp_file(32'd1, 32'd2, bmpdec_pkg::BPP_RGB, FAULT_NONE, -1);

      // Random part: mostly well-formed files with random geometry and
      // pixel bytes, then damaged headers, cut-short files and noise.
      while (file_bytes.size() < 2000) begin
         roll = $urandom_range(99);
         w = ($urandom_range(19) == 0) ? 32'($urandom_range(60, 70)) : 32'($urandom_range(1, 9));
         h = (w > 32'd9) ? 32'd1 : pick_height();
         bpp = $urandom_range(1) ? bmpdec_pkg::BPP_RGBA : bmpdec_pkg::BPP_RGB;
         if (roll < 65) begin
            queue_bmp_file(w, h, bpp, FAULT_NONE, -1);
         end else if (roll < 82) begin
            case ($urandom_range(8))
               0: queue_bmp_file(w, h, bpp, FAULT_SIGNATURE, HEADER_BYTES + $urandom_range(6));
               1: queue_bmp_file(w, h, bpp, FAULT_INFO_SIZE, HEADER_BYTES + $urandom_range(6));
               2: queue_bmp_file(w, h, bpp, FAULT_PLANES, HEADER_BYTES + $urandom_range(6));
               3: queue_bmp_file(w, h, bpp, FAULT_COMPRESSION, HEADER_BYTES + $urandom_range(6));
               4: queue_bmp_file(32'd0, h, bpp, FAULT_NONE, HEADER_BYTES + $urandom_range(6));
               5: queue_bmp_file({1'b1, 31'($urandom)}, h, bpp, FAULT_NONE,
                                 HEADER_BYTES + $urandom_range(6));
               6: queue_bmp_file(COORD_LIMIT + 32'd1 + 32'($urandom_range(1000)), h, bpp,
                                 FAULT_NONE, HEADER_BYTES + $urandom_range(6));
               7: begin
                  h = COORD_LIMIT + 32'd1 + 32'($urandom_range(1000));
                  queue_bmp_file(w, $urandom_range(1) ? h : -h, bpp, FAULT_NONE,
                                 HEADER_BYTES + $urandom_range(6));
               end
               default: queue_bmp_file(w, h, ($urandom_range(3) == 0) ? 16'd16 :
                                       (16'($urandom) | 16'h0040), FAULT_NONE,
                                       HEADER_BYTES + $urandom_range(6));
            endcase
         end else if (roll < 92) begin
            queue_bmp_file(w, h, bpp, FAULT_NONE,
                           $urandom_range(1, HEADER_BYTES + 20 * int'(w)));
         end else begin
            queue_noise($urandom_range(1, 20), 1'b1);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last byte to go out and every predicted beat to come
      // back, then leave room for any beat that should not be there.
      while (file_bytes.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("bmp_stream_pixel_decoder: match");
      end else begin
         $display("bmp_stream_pixel_decoder: mismatch");
      end
      $finish;
   end

   // Whenever steady_timer wraps, each side may switch to a stretch without
   // idling, so runs at full rate alternate with runs full of gaps and stalls.
   logic [6:0] steady_timer = '0;
   logic       req_steady = 1'b0;
   logic       rsp_steady = 1'b0;

   always @(posedge clock) begin
      steady_timer <= steady_timer + 7'd1;
      if (steady_timer == '0) begin
         req_steady <= ($urandom_range(3) == 0);
         rsp_steady <= ($urandom_range(3) == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Driver. A beat is taken by the decoder at an edge where valid is high
   // and stall is low; that is also where the prediction advances. A new
   // beat (or a gap) is only chosen once the current one has gone, so a
   // stalled beat never changes.
   // ------------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) decode_file_byte(req_payload);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (file_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_payload <= file_bytes.pop_front();
               send_gap <= req_steady ? 0 : pick_idle_cycles();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Each beat taken from the decoder is compared with the oldest
   // prediction; the result side stalls at random in the meantime.
   // ------------------------------------------------------------------------
   int hold_cycles = 0;

   task automatic report_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      bmpdec_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result beat with none expected: status %0d, x %0d, row %0d",
                      rsp_payload.status, rsp_payload.pixel_x, rsp_payload.pixel_row);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               report_field("pixel_x", want.pixel_x, rsp_payload.pixel_x);
               report_field("pixel_row", want.pixel_row, rsp_payload.pixel_row);
               report_field("red", 16'(want.red), 16'(rsp_payload.red));
               report_field("green", 16'(want.green), 16'(rsp_payload.green));
               report_field("blue", 16'(want.blue), 16'(rsp_payload.blue));
               report_field("alpha", 16'(want.alpha), 16'(rsp_payload.alpha));
               report_field("status", 16'(want.status), 16'(rsp_payload.status));
               report_field("last_pixel", 16'(want.last_pixel), 16'(rsp_payload.last_pixel));
            end
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else if (!rsp_steady && $urandom_range(4) == 0) begin
            rsp_stall <= 1'b1;
            hold_cycles <= pick_idle_cycles();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a decoder that stops taking or returning beats ends the run.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bmp_stream_pixel_decoder: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
